### design/stll_pkg.sv
// Types and constants shared by the slot table linked list modules.
`default_nettype none
package stll_pkg;

    localparam int SLOT_COUNT = 64;
    localparam int IDX_W      = $clog2(SLOT_COUNT);
    localparam int LINK_W     = IDX_W + 1;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [LINK_W-1:0] t_link;

    localparam t_link NONE_LINK = t_link'(SLOT_COUNT);

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DELETE = 1'b1;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_FULL   = 2'd1;
    localparam logic [1:0] STAT_UNUSED = 2'd2;

    typedef struct packed {
        logic kind;
        t_idx slot;
    } t_cmd;

    typedef struct packed {
        t_idx       slot_index;
        logic [1:0] status;
        t_link      head_slot;
        t_link      tail_slot;
        t_link      occupancy;
    } t_result;

    typedef struct packed {
        logic  en;
        t_idx  addr;
        t_link data;
    } t_link_wr;

    typedef struct packed {
        logic en;
        t_idx addr;
        t_idx data;
    } t_stack_wr;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage
`default_nettype wire

### design/slot_table_linked_list_core.sv
// Top level of the slot table linked list: control plus link and free-stack memories.
//
//   Channel   Signals                    Direction  Handshake
//   command   start, busy, i_cmd         in         beat taken when start and not busy
//   result    o_done, o_result           out        beat valid for the single o_done cycle
//
// On the accept edge the link and free-stack memories are read; in the ST_EXEC
// state the read-modify-write is done and the result is registered at its end.
// The result strobe appears in the cycle after ST_EXEC, when a new command may
// already be taken. Reset is synchronous and clears pointers, counters and
// in-use flags; memory contents are not cleared. The receiver cannot stall.
`default_nettype none
module slot_table_linked_list_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire stll_pkg::t_cmd     i_cmd,
    output logic                    busy,
    output logic                    o_done,
    output stll_pkg::t_result       o_result
);
    import stll_pkg::*;

    t_link     prev_rdata;
    t_link     next_rdata;
    t_idx      stack_rdata;
    t_idx      stack_raddr;
    t_link_wr  prev_wr;
    t_link_wr  next_wr;
    t_stack_wr stack_wr;

    stll_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .i_cmd         (i_cmd),
        .busy          (busy),
        .o_done        (o_done),
        .o_result      (o_result),
        .o_stack_raddr (stack_raddr),
        .i_prev_rdata  (prev_rdata),
        .i_next_rdata  (next_rdata),
        .i_stack_rdata (stack_rdata),
        .o_prev_wr     (prev_wr),
        .o_next_wr     (next_wr),
        .o_stack_wr    (stack_wr)
    );

    stll_ram #(.WIDTH(LINK_W), .DEPTH(SLOT_COUNT)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prev_wr.en),
        .i_waddr (prev_wr.addr),
        .i_wdata (prev_wr.data),
        .i_raddr (i_cmd.slot),
        .o_rdata (prev_rdata)
    );

    stll_ram #(.WIDTH(LINK_W), .DEPTH(SLOT_COUNT)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_wr.en),
        .i_waddr (next_wr.addr),
        .i_wdata (next_wr.data),
        .i_raddr (i_cmd.slot),
        .o_rdata (next_rdata)
    );

    stll_ram #(.WIDTH(IDX_W), .DEPTH(SLOT_COUNT)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stack_wr.en),
        .i_waddr (stack_wr.addr),
        .i_wdata (stack_wr.data),
        .i_raddr (stack_raddr),
        .o_rdata (stack_rdata)
    );

endmodule
`default_nettype wire

### design/stll_ram.sv
// Simple dual-port synchronous RAM with one write port and one registered read port.
`default_nettype none
module stll_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule
`default_nettype wire

### design/stll_ctrl.sv
// Sequencer, list pointers, slot allocation and in-use flags of the slot table.
`default_nettype none
module stll_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire stll_pkg::t_cmd     i_cmd,
    output logic                    busy,
    output logic                    o_done,
    output stll_pkg::t_result       o_result,
    output stll_pkg::t_idx          o_stack_raddr,
    input  wire stll_pkg::t_link    i_prev_rdata,
    input  wire stll_pkg::t_link    i_next_rdata,
    input  wire stll_pkg::t_idx     i_stack_rdata,
    output stll_pkg::t_link_wr      o_prev_wr,
    output stll_pkg::t_link_wr      o_next_wr,
    output stll_pkg::t_stack_wr     o_stack_wr
);
    import stll_pkg::*;

    t_state          r_state, n_state;
    logic            r_kind;
    t_idx            r_slot;
    t_link           r_head, n_head;
    t_link           r_tail, n_tail;
    t_link           r_bump, n_bump;
    t_link           r_fc, n_fc;
    logic [SLOT_COUNT-1:0] r_in_use, n_in_use;
    logic            r_done, n_done;
    t_result         r_result, n_result;
    logic            accept;
    logic            exec;
    t_idx            s;
    t_link           p, n;
    logic [1:0]      stat;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy = 1'b0;
        exec = 1'b0;
        case (r_state)
            ST_IDLE: busy = 1'b0;
            ST_EXEC: begin
                busy = 1'b1;
                exec = 1'b1;
            end
            default: busy = 1'b0;
        endcase
    end

    assign accept        = start && !busy;
    assign o_stack_raddr = r_fc[IDX_W-1:0] - t_idx'(1);

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_bump    = r_bump;
        n_fc      = r_fc;
        n_in_use  = r_in_use;
        o_prev_wr = '0;
        o_next_wr = '0;
        o_stack_wr = '0;
        s         = r_slot;
        stat      = STAT_OK;
        p         = (t_link'(r_slot) == r_head) ? NONE_LINK : i_prev_rdata;
        n         = (t_link'(r_slot) == r_tail) ? NONE_LINK : i_next_rdata;
        if (exec) begin
            if (r_kind == KIND_INSERT) begin
                if (r_bump < NONE_LINK) begin
                    s      = r_bump[IDX_W-1:0];
                    n_bump = r_bump + t_link'(1);
                end else if (r_fc != '0) begin
                    s    = i_stack_rdata;
                    n_fc = r_fc - t_link'(1);
                end else begin
                    s    = '0;
                    stat = STAT_FULL;
                end
                if (stat == STAT_OK) begin
                    o_prev_wr = '{en: 1'b1, addr: s, data: r_tail};
                    if (r_head == NONE_LINK) begin
                        n_head = t_link'(s);
                    end else begin
                        o_next_wr = '{en: 1'b1, addr: r_tail[IDX_W-1:0], data: t_link'(s)};
                    end
                    n_tail      = t_link'(s);
                    n_in_use[s] = 1'b1;
                end
            end else begin
                if (!r_in_use[r_slot]) begin
                    stat = STAT_UNUSED;
                end else begin
                    if (p != NONE_LINK) begin
                        o_next_wr = '{en: 1'b1, addr: p[IDX_W-1:0], data: n};
                    end else begin
                        n_head = n;
                    end
                    if (n != NONE_LINK) begin
                        o_prev_wr = '{en: 1'b1, addr: n[IDX_W-1:0], data: p};
                    end else begin
                        n_tail = p;
                    end
                    n_in_use[r_slot] = 1'b0;
                    if (r_fc < NONE_LINK) begin
                        o_stack_wr = '{en: 1'b1, addr: r_fc[IDX_W-1:0], data: r_slot};
                        n_fc       = r_fc + t_link'(1);
                    end
                end
            end
        end
        n_done   = exec;
        n_result = '{slot_index: s, status: stat, head_slot: n_head,
                     tail_slot: n_tail, occupancy: n_bump - n_fc};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_head   <= NONE_LINK;
            r_tail   <= NONE_LINK;
            r_bump   <= '0;
            r_fc     <= '0;
            r_in_use <= '0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_bump   <= n_bump;
            r_fc     <= n_fc;
            r_in_use <= n_in_use;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_cmd.kind;
            r_slot <= i_cmd.slot;
        end
        if (exec) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule
`default_nettype wire
